// File: rtl/window_row_band_counter_top_macros.svh
// Assertion macros used by the window row band counter back end.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef WINDOW_ROW_BAND_COUNTER_TOP_MACROS_SVH
`define WINDOW_ROW_BAND_COUNTER_TOP_MACROS_SVH

// Condition in the same cycle implies the consequence in the same cycle.
`define WRBC_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Condition in one cycle implies the consequence in the next cycle.
`define WRBC_LEADS_TO(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/wrbc_pkg.sv
// Shared types and constants of the window row band counter.
// Used by every RTL module of the block; depends on nothing.
package wrbc_pkg;

    localparam int COL_W       = 12;
    localparam int BOUND_W     = 13;
    localparam int ROW_W       = 12;
    localparam int SUM_W       = 20;
    localparam int PIX_W       = 8;
    localparam int OUT_W       = 12;
    localparam int CFG_ADDR_W  = 3;
    localparam int GREY_LEVEL  = 239;
    localparam int NEAR_SQ     = 900;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int DIVIDEND_W  = 13;
    localparam int DIV_CNT_W   = $clog2(DIVIDEND_W + 1);

    localparam logic [CFG_ADDR_W-1:0] CFG_LEFT_COL     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_RIGHT_COL    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_TOP_LIMIT    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_BOTTOM_LIMIT = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_PITCH        = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_ITEM_HEIGHT  = 3'd5;

    typedef struct packed {
        logic [COL_W-1:0]   left_col;
        logic [BOUND_W-1:0] right_col;
        logic [ROW_W-1:0]   top_limit;
        logic [BOUND_W-1:0] bottom_limit;
        logic [ROW_W-1:0]   pitch;
        logic [ROW_W-1:0]   item_height;
    } cfg_t;

    typedef struct packed {
        logic [SUM_W-1:0] r_sum;
        logic [SUM_W-1:0] g_sum;
        logic [SUM_W-1:0] b_sum;
        logic             cnear;
        logic             in_rows;
        logic [ROW_W-1:0] row;
        logic             frame_end;
    } row_rec_t;

endpackage

// File: rtl/wrbc_front.sv
// Front end: counts columns and rows, accumulates window sums, runs the centre test.
// Emits one row record per finished row. Depends on wrbc_pkg.
module wrbc_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  wrbc_pkg::cfg_t               cfg,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [wrbc_pkg::PIX_W-1:0]   red,
    input  logic [wrbc_pkg::PIX_W-1:0]   green,
    input  logic [wrbc_pkg::PIX_W-1:0]   blue,
    input  logic                         row_end,
    input  logic                         frame_end,
    input  logic                         q_full,
    output logic                         push,
    output wrbc_pkg::row_rec_t           rec
);

    logic [wrbc_pkg::COL_W-1:0]   col_reg, col_next;
    logic [wrbc_pkg::ROW_W-1:0]   row_reg, row_next;
    logic [wrbc_pkg::SUM_W-1:0]   r_sum_reg, r_sum_next, g_sum_reg, g_sum_next;
    logic [wrbc_pkg::SUM_W-1:0]   b_sum_reg, b_sum_next;
    logic                         cnear_reg, cnear_next;
    logic [wrbc_pkg::SUM_W-1:0]   r_acc, g_acc, b_acc;
    logic                         cnear_acc;
    logic                         accept, eol, in_win, at_centre, near;
    logic [wrbc_pkg::BOUND_W:0]   centre_sum;
    logic [wrbc_pkg::BOUND_W-1:0] centre;
    logic [17:0]                  near_dsq;

    function automatic logic [15:0] sq_dist(input logic [7:0] c);
        logic [7:0] d;
        d = (c >= 8'(wrbc_pkg::GREY_LEVEL)) ? c - 8'(wrbc_pkg::GREY_LEVEL)
                                              : 8'(wrbc_pkg::GREY_LEVEL) - c;
        return 16'(d) * 16'(d);
    endfunction

    always_comb
    begin
        accept     = in_valid && in_ready;
        eol        = row_end || frame_end;
        centre_sum = {2'b0, cfg.left_col} + {1'b0, cfg.right_col};
        centre     = centre_sum[wrbc_pkg::BOUND_W:1];
        in_win     = ({1'b0, col_reg} >= {1'b0, cfg.left_col}) && ({1'b0, col_reg} < cfg.right_col);
        at_centre  = {1'b0, col_reg} == centre;
        near_dsq   = {2'b0, sq_dist(red)} + {2'b0, sq_dist(green)} + {2'b0, sq_dist(blue)};
        near       = near_dsq < 18'(wrbc_pkg::NEAR_SQ);
        r_acc      = in_win ? r_sum_reg + wrbc_pkg::SUM_W'(red) : r_sum_reg;
        g_acc      = in_win ? g_sum_reg + wrbc_pkg::SUM_W'(green) : g_sum_reg;
        b_acc      = in_win ? b_sum_reg + wrbc_pkg::SUM_W'(blue) : b_sum_reg;
        cnear_acc  = at_centre ? near : cnear_reg;

        col_next   = col_reg;
        row_next   = row_reg;
        r_sum_next = r_sum_reg;
        g_sum_next = g_sum_reg;
        b_sum_next = b_sum_reg;
        cnear_next = cnear_reg;
        if (accept)
        begin
            if (eol)
            begin
                col_next   = '0;
                r_sum_next = '0;
                g_sum_next = '0;
                b_sum_next = '0;
                cnear_next = 1'b0;
                row_next   = frame_end ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next   = col_reg + 1'b1;
                r_sum_next = r_acc;
                g_sum_next = g_acc;
                b_sum_next = b_acc;
                cnear_next = cnear_acc;
            end
        end

        in_ready      = !q_full;
        push          = accept && eol;
        rec.r_sum     = r_acc;
        rec.g_sum     = g_acc;
        rec.b_sum     = b_acc;
        rec.cnear     = cnear_acc;
        rec.in_rows   = ({1'b0, row_reg} >= {1'b0, cfg.top_limit})
                        && ({1'b0, row_reg} < cfg.bottom_limit);
        rec.row       = row_reg;
        rec.frame_end = frame_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            r_sum_reg <= '0;
            g_sum_reg <= '0;
            b_sum_reg <= '0;
            cnear_reg <= 1'b0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            r_sum_reg <= r_sum_next;
            g_sum_reg <= g_sum_next;
            b_sum_reg <= b_sum_next;
            cnear_reg <= cnear_next;
        end
    end

endmodule

// File: rtl/wrbc_queue.sv
// Short first-in first-out queue of row records between front and back end.
// Depends on wrbc_pkg.
module wrbc_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  wrbc_pkg::row_rec_t push_data,
    input  logic               pop,
    output wrbc_pkg::row_rec_t pop_data,
    output logic               full,
    output logic               empty
);

    wrbc_pkg::row_rec_t               mem_reg [wrbc_pkg::QUEUE_DEPTH];
    logic [wrbc_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [wrbc_pkg::QUEUE_PTR_W:0]   cnt_reg, cnt_next;
    logic                             do_push, do_pop;

    always_comb
    begin
        full     = cnt_reg == (wrbc_pkg::QUEUE_PTR_W + 1)'(wrbc_pkg::QUEUE_DEPTH);
        empty    = cnt_reg == '0;
        do_push  = push && !full;
        do_pop   = pop && !empty;
        pop_data = mem_reg[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == wrbc_pkg::QUEUE_PTR_W'(wrbc_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == wrbc_pkg::QUEUE_PTR_W'(wrbc_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/wrbc_div.sv
// Restoring divider that retires one quotient bit per cycle.
// Depends on wrbc_pkg.
module wrbc_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [wrbc_pkg::DIVIDEND_W-1:0] dividend,
    input  logic [wrbc_pkg::ROW_W-1:0]      divisor,
    output logic                            done,
    output logic [wrbc_pkg::DIVIDEND_W-1:0] quotient
);

    logic                            busy_reg, busy_next, done_reg, done_next;
    logic [wrbc_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [wrbc_pkg::ROW_W-1:0]      rem_reg, rem_next, dvs_reg, dvs_next;
    logic [wrbc_pkg::DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [wrbc_pkg::ROW_W:0]        trial, trial_sub;
    logic                            fits;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[wrbc_pkg::DIVIDEND_W-1]};
        fits      = trial >= {1'b0, dvs_reg};
        trial_sub = trial - {1'b0, dvs_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = wrbc_pkg::DIV_CNT_W'(wrbc_pkg::DIVIDEND_W);
            rem_next  = '0;
            dvs_next  = divisor;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial_sub[wrbc_pkg::ROW_W-1:0] : trial[wrbc_pkg::ROW_W-1:0];
            quo_next = {quo_reg[wrbc_pkg::DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == wrbc_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        done     = done_reg;
        quotient = quo_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

endmodule

// File: rtl/wrbc_back.sv
// Back end: mean colour test per row record, band tracking and frame result with stack count.
// Depends on wrbc_pkg, wrbc_div and the assertion macro header.
`include "window_row_band_counter_top_macros.svh"

module wrbc_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  wrbc_pkg::cfg_t                cfg,
    input  logic                          q_empty,
    input  wrbc_pkg::row_rec_t            q_data,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          found,
    output logic [wrbc_pkg::OUT_W-1:0]    top_row,
    output logic [wrbc_pkg::OUT_W-1:0]    bottom_row,
    output logic [wrbc_pkg::OUT_W-1:0]    item_count
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SQR   = 6'b000010,
        ST_JUDGE = 6'b000100,
        ST_PRE   = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_EMIT  = 6'b100000
    } state_t;

    state_t                       state_reg, state_next;
    wrbc_pkg::row_rec_t           rec_reg, rec_next;
    logic [20:0]                  ref_reg, ref_next;
    logic [25:0]                  wsq_reg, wsq_next;
    logic [35:0]                  limit_reg, limit_next;
    logic [43:0]                  acc_reg, acc_next;
    logic [1:0]                   ch_reg, ch_next;
    logic                         found_reg, found_next;
    logic [wrbc_pkg::ROW_W-1:0]   first_reg, first_next, last_reg, last_next;
    logic                         zero_reg, zero_next, npos_reg, npos_next;
    logic [wrbc_pkg::OUT_W-1:0]   count_reg, count_next;
    logic                         out_valid_reg, out_valid_next;
    logic                         out_found_reg, out_found_next;
    logic [wrbc_pkg::OUT_W-1:0]   out_top_reg, out_top_next, out_bottom_reg, out_bottom_next;
    logic [wrbc_pkg::OUT_W-1:0]   out_count_reg, out_count_next;

    logic                         win_ok, qualifies, out_free, div_start, div_done;
    logic [wrbc_pkg::BOUND_W-1:0] width;
    logic [wrbc_pkg::SUM_W-1:0]   sel_sum;
    logic [21:0]                  diff, neg_diff;
    logic [20:0]                  mag;
    logic [41:0]                  sq;
    logic [13:0]                  n_val, q_inc;
    logic [wrbc_pkg::ROW_W-1:0]   divisor;
    logic [wrbc_pkg::DIVIDEND_W-1:0] quotient;

    wrbc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (n_val[wrbc_pkg::DIVIDEND_W-1:0]),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        win_ok  = cfg.right_col > {1'b0, cfg.left_col};
        width   = cfg.right_col - {1'b0, cfg.left_col};
        case (ch_reg)
            2'd0:    sel_sum = rec_reg.r_sum;
            2'd1:    sel_sum = rec_reg.g_sum;
            default: sel_sum = rec_reg.b_sum;
        endcase
        diff     = {2'b0, sel_sum} - {1'b0, ref_reg};
        neg_diff = 22'd0 - diff;
        mag      = diff[21] ? neg_diff[20:0] : diff[20:0];
        sq       = 42'(mag) * 42'(mag);
        qualifies = rec_reg.in_rows && rec_reg.cnear && win_ok
                    && (acc_reg < {8'b0, limit_reg});
        n_val    = {2'b0, last_reg} - {2'b0, first_reg} - {2'b0, cfg.item_height} + 14'd2;
        divisor  = (cfg.pitch == '0) ? wrbc_pkg::ROW_W'(1) : cfg.pitch;
        q_inc    = {1'b0, quotient} + 14'd1;
        out_free = !out_valid_reg || out_ready;

        state_next      = state_reg;
        rec_next        = rec_reg;
        ref_next        = ref_reg;
        wsq_next        = wsq_reg;
        limit_next      = limit_reg;
        acc_next        = acc_reg;
        ch_next         = ch_reg;
        found_next      = found_reg;
        first_next      = first_reg;
        last_next       = last_reg;
        zero_next       = zero_reg;
        npos_next       = npos_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_found_next  = out_found_reg;
        out_top_next    = out_top_reg;
        out_bottom_next = out_bottom_reg;
        out_count_next  = out_count_reg;
        pop             = 1'b0;
        div_start       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    pop        = 1'b1;
                    rec_next   = q_data;
                    ref_next   = 21'(width) * 21'(wrbc_pkg::GREY_LEVEL);
                    wsq_next   = 26'(width) * 26'(width);
                    acc_next   = '0;
                    ch_next    = 2'd0;
                    state_next = ST_SQR;
                end
            end
            ST_SQR:
            begin
                acc_next = acc_reg + {2'b0, sq};
                ch_next  = ch_reg + 1'b1;
                if (ch_reg == 2'd0)
                begin
                    limit_next = 36'(wsq_reg) * 36'(wrbc_pkg::NEAR_SQ);
                end
                if (ch_reg == 2'd2)
                begin
                    state_next = ST_JUDGE;
                end
            end
            ST_JUDGE:
            begin
                if (qualifies)
                begin
                    if (!found_reg)
                    begin
                        first_next = rec_reg.row;
                    end
                    last_next  = rec_reg.row;
                    found_next = 1'b1;
                end
                state_next = rec_reg.frame_end ? ST_PRE : ST_IDLE;
            end
            ST_PRE:
            begin
                zero_next  = !found_reg || (last_reg <= first_reg);
                npos_next  = !n_val[13] && (n_val != '0);
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    if (zero_reg)
                    begin
                        count_next = '0;
                    end
                    else if (!npos_reg)
                    begin
                        count_next = wrbc_pkg::OUT_W'(1);
                    end
                    else if (q_inc[13:12] != 2'b00)
                    begin
                        count_next = '1;
                    end
                    else
                    begin
                        count_next = q_inc[wrbc_pkg::OUT_W-1:0];
                    end
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_found_next  = found_reg;
                    out_top_next    = first_reg;
                    out_bottom_next = last_reg;
                    out_count_next  = count_reg;
                    found_next      = 1'b0;
                    first_next      = '0;
                    last_next       = '0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid  = out_valid_reg;
        found      = out_found_reg;
        top_row    = out_top_reg;
        bottom_row = out_bottom_reg;
        item_count = out_count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            found_reg     <= 1'b0;
            first_reg     <= '0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            found_reg     <= found_next;
            first_reg     <= first_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg        <= rec_next;
        ref_reg        <= ref_next;
        wsq_reg        <= wsq_next;
        limit_reg      <= limit_next;
        acc_reg        <= acc_next;
        ch_reg         <= ch_next;
        zero_reg       <= zero_next;
        npos_reg       <= npos_next;
        count_reg      <= count_next;
        out_found_reg  <= out_found_next;
        out_top_reg    <= out_top_next;
        out_bottom_reg <= out_bottom_next;
        out_count_reg  <= out_count_next;
    end

    `WRBC_IMPLIES(a_pop_not_empty, pop, !q_empty, "row record taken from an empty queue")
    `WRBC_IMPLIES(a_band_clear, !found_reg, (first_reg == '0) && (last_reg == '0), "band rows set without a qualifying row")
    `WRBC_IMPLIES(a_div_done_in_div, div_done, state_reg == ST_DIV, "divider finished outside the divide step")
    `WRBC_LEADS_TO(a_emit_valid, (state_reg == ST_EMIT) && out_free, out_valid_reg, "frame result not presented after emit")
    `WRBC_IMPLIES(a_count_order, out_valid_reg && (out_count_reg != '0), out_bottom_reg > out_top_reg, "nonzero count without bottom below top")

endmodule

// File: rtl/window_row_band_counter_top.sv
// Window row band counter top level: configuration registers, front end, row queue, back end.
// Pixels are taken one per cycle while the row queue is not full; each finished row passes
// the back end's idle, square-sum and judge states, so rows shorter than 5 pixels fill the
// 4-entry row queue and then stall the input. A frame-end pixel's result becomes valid after
// its judge, pre-divide, divide and emit states; the serial stack-count divider dominates them.
// Asynchronous active-low reset clears counters, sums and the band and loads default config.
module window_row_band_counter_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [wrbc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [wrbc_pkg::BOUND_W-1:0]      cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [23:0]                       s_axis_tdata,  // red, green, blue
    input  logic                              s_axis_tlast,  // row_end
    input  logic                              s_axis_tuser,  // frame_end
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [39:0]                       m_axis_tdata   // found, top_row, bottom_row, item_count
);

    wrbc_pkg::cfg_t           cfg_reg, cfg_next;
    wrbc_pkg::row_rec_t       push_rec, pop_rec;
    logic                     push, pop, q_full, q_empty;
    logic                     found;
    logic [wrbc_pkg::OUT_W-1:0] top_row, bottom_row, item_count;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                wrbc_pkg::CFG_LEFT_COL:     cfg_next.left_col     = cfg_wdata[wrbc_pkg::COL_W-1:0];
                wrbc_pkg::CFG_RIGHT_COL:    cfg_next.right_col    = cfg_wdata;
                wrbc_pkg::CFG_TOP_LIMIT:    cfg_next.top_limit    = cfg_wdata[wrbc_pkg::ROW_W-1:0];
                wrbc_pkg::CFG_BOTTOM_LIMIT: cfg_next.bottom_limit = cfg_wdata;
                wrbc_pkg::CFG_PITCH:        cfg_next.pitch        = cfg_wdata[wrbc_pkg::ROW_W-1:0];
                wrbc_pkg::CFG_ITEM_HEIGHT:  cfg_next.item_height  = cfg_wdata[wrbc_pkg::ROW_W-1:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
        m_axis_tdata = {3'b000, item_count, bottom_row, top_row, found};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.left_col     <= '0;
            cfg_reg.right_col    <= wrbc_pkg::BOUND_W'(1);
            cfg_reg.top_limit    <= '0;
            cfg_reg.bottom_limit <= wrbc_pkg::BOUND_W'(1);
            cfg_reg.pitch        <= wrbc_pkg::ROW_W'(1);
            cfg_reg.item_height  <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    wrbc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .red       (s_axis_tdata[7:0]),
        .green     (s_axis_tdata[15:8]),
        .blue      (s_axis_tdata[23:16]),
        .row_end   (s_axis_tlast),
        .frame_end (s_axis_tuser),
        .q_full    (q_full),
        .push      (push),
        .rec       (push_rec)
    );

    wrbc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_rec),
        .pop       (pop),
        .pop_data  (pop_rec),
        .full      (q_full),
        .empty     (q_empty)
    );

    wrbc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_empty    (q_empty),
        .q_data     (pop_rec),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .found      (found),
        .top_row    (top_row),
        .bottom_row (bottom_row),
        .item_count (item_count)
    );

endmodule
